### design/json_html_safe_escaper_macros.svh
// Assertion macros for the HTML-safe JSON escaper.
// Uses the aclk / aresetn names of the including module; no other dependencies.
`ifndef JSON_HTML_SAFE_ESCAPER_MACROS_SVH
`define JSON_HTML_SAFE_ESCAPER_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define JHSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("jhse assertion failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define JHSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("jhse assertion failed");

`endif

### design/jhse_pkg.sv
// Shared types, constants and byte-sequence functions for the escaper.
// No dependencies; imported by every module of the block.
package jhse_pkg;

    localparam logic [7:0] B_AMP   = 8'h26;
    localparam logic [7:0] B_GT    = 8'h3E;
    localparam logic [7:0] B_LT    = 8'h3C;
    localparam logic [7:0] B_E2    = 8'hE2;
    localparam logic [7:0] B_80    = 8'h80;
    localparam logic [7:0] B_A8    = 8'hA8;
    localparam logic [7:0] B_A9    = 8'hA9;
    localparam logic [7:0] B_BSL   = 8'h5C;
    localparam logic [7:0] B_U     = 8'h75;

    localparam logic [31:0] HEX_0026 = "0026";
    localparam logic [31:0] HEX_003E = "003e";
    localparam logic [31:0] HEX_003C = "003c";
    localparam logic [31:0] HEX_2028 = "2028";
    localparam logic [31:0] HEX_2029 = "2029";

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // held prefix state
    typedef enum logic [2:0] {
        HOLD_NONE = 3'b001,
        HOLD_E2   = 3'b010,
        HOLD_E280 = 3'b100
    } hold_state_t;

    typedef enum logic [1:0] {
        BODY_NONE = 2'd0,
        BODY_LIT  = 2'd1,
        BODY_ESC  = 2'd2
    } body_kind_t;

    typedef enum logic [2:0] {
        ESC_0026 = 3'd0,
        ESC_003E = 3'd1,
        ESC_003C = 3'd2,
        ESC_2028 = 3'd3,
        ESC_2029 = 3'd4
    } esc_code_t;

    // one expansion command: prefix bytes, then a body
    typedef struct packed {
        logic [1:0] pre;   // 0: none, 1: E2, 2: E2 80
        body_kind_t kind;
        esc_code_t  esc;
        logic [7:0] lit;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic        push;
        hold_state_t held;
    } front_stat_t;

    typedef struct packed {
        logic              full;
        logic              valid;
        logic [QCNT_W-1:0] count;
    } queue_stat_t;

    function automatic logic [3:0] cmd_len(cmd_t c);
        logic [3:0] body;
        body = 4'd0;
        case (c.kind)
            BODY_LIT: body = 4'd1;
            BODY_ESC: body = 4'd6;
            default:  body = 4'd0;
        endcase
        return {2'b00, c.pre} + body;
    endfunction

    function automatic logic [7:0] esc_char(esc_code_t e, logic [1:0] k);
        logic [31:0] s;
        s = HEX_0026;
        case (e)
            ESC_0026: s = HEX_0026;
            ESC_003E: s = HEX_003E;
            ESC_003C: s = HEX_003C;
            ESC_2028: s = HEX_2028;
            ESC_2029: s = HEX_2029;
            default:  s = HEX_0026;
        endcase
        return s[8*(3-k) +: 8];
    endfunction

    function automatic logic [7:0] cmd_byte(cmd_t c, logic [2:0] idx);
        logic [2:0] j;
        logic [7:0] b;
        j = idx - {1'b0, c.pre};
        b = c.lit;
        if (idx < {1'b0, c.pre}) begin
            b = (idx == 3'd0) ? B_E2 : B_80;
        end else if (c.kind == BODY_ESC) begin
            case (j)
                3'd0:    b = B_BSL;
                3'd1:    b = B_U;
                default: b = esc_char(c.esc, 2'(j - 3'd2));
            endcase
        end
        return b;
    endfunction

endpackage

### design/jhse_front.sv
// Front end: accepts input bytes, tracks the held E2 / E2 80 prefix and
// turns each byte into an expansion command. Depends on jhse_pkg.
module jhse_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output jhse_pkg::cmd_t        cmd,
    output jhse_pkg::front_stat_t stat
);
    import jhse_pkg::*;

    hold_state_t held_reg, held_next;
    cmd_t        c;
    logic        fresh_hold;

    always_comb begin
        c          = '0;
        c.kind     = BODY_LIT;
        c.esc      = ESC_0026;
        c.lit      = in_byte;
        c.last     = in_last;
        fresh_hold = 1'b0;
        // byte examined with nothing held
        case (in_byte)
            B_AMP: begin c.kind = BODY_ESC; c.esc = ESC_0026; end
            B_GT:  begin c.kind = BODY_ESC; c.esc = ESC_003E; end
            B_LT:  begin c.kind = BODY_ESC; c.esc = ESC_003C; end
            B_E2: begin
                if (!in_last) begin
                    c.kind     = BODY_NONE;
                    fresh_hold = 1'b1;
                end
            end
            default: c.kind = BODY_LIT;
        endcase
        held_next = fresh_hold ? HOLD_E2 : HOLD_NONE;
        case (held_reg)
            HOLD_E2: begin
                if (in_byte == B_80 && !in_last) begin
                    c.kind    = BODY_NONE;
                    held_next = HOLD_E280;
                end else begin
                    c.pre = 2'd1;
                end
            end
            HOLD_E280: begin
                if (in_byte == B_A8 || in_byte == B_A9) begin
                    c.kind    = BODY_ESC;
                    c.esc     = (in_byte == B_A8) ? ESC_2028 : ESC_2029;
                    held_next = HOLD_NONE;
                end else begin
                    c.pre = 2'd2;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= HOLD_NONE;
        end else if (in_fire) begin
            held_reg <= held_next;
        end
    end

    assign cmd       = c;
    assign stat.push = in_fire && (c.pre != 2'd0 || c.kind != BODY_NONE);
    assign stat.held = held_reg;
endmodule

### design/jhse_queue.sv
// Short command queue between front and back end.
// Depends on jhse_pkg for the command type and depth.
module jhse_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  jhse_pkg::cmd_t        wr_cmd,
    input  logic                  pop,
    output jhse_pkg::cmd_t        rd_cmd,
    output jhse_pkg::queue_stat_t stat
);
    import jhse_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.valid = (count_reg != '0);
    assign stat.count = count_reg;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign rd_cmd     = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule

### design/jhse_back.sv
// Back end: walks each queued command byte by byte into the output register.
// Depends on jhse_pkg for the command type and byte functions.
module jhse_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    input  jhse_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic [2:0]     idx,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import jhse_pkg::*;

    logic [2:0] idx_reg;
    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       load;
    logic       done;

    assign load    = cmd_valid && (!valid_reg || m_tready);
    assign done    = ({1'b0, idx_reg} == cmd_len(cmd) - 4'd1);
    assign cmd_pop = load && done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= done ? 3'd0 : idx_reg + 3'd1;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= cmd_byte(cmd, idx_reg);
            last_reg <= cmd.last && done;
        end
    end

    assign idx      = idx_reg;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
endmodule

### design/json_html_safe_escaper.sv
// Top level of the HTML-safe JSON escaper: front end, command queue, back end.
// Depends on jhse_pkg, jhse_front, jhse_queue, jhse_back and the macro header.
//
// Usage:
//   s_ channel carries the input string, one byte per item, s_tlast on the
//   final byte. m_ channel carries the escaped bytes, m_tlast on the final
//   output byte of the string.
//   '&', '>', '<' expand to six-byte \u00xx escapes; E2 80 A8 / E2 80 A9 to
//   \u2028 / \u2029. An E2 or E2 80 is held until the next byte decides it.
// Path: an item that produces output is written into the queue when accepted; the back end
//   then loads its first byte into the output register.
// Throughput: one output byte per cycle while m_tready is high, set by the back end
//   walking one command byte per cycle; plain bytes therefore flow at one item per cycle.
//   An escape is six command bytes (eight behind a broken E2 80), which the back
//   end walks while the four-entry queue absorbs further input before s_tready drops.
// Reset: aresetn low clears the held prefix, the queue and the output valid.
// Stall: with m_tready low the output register holds; the queue fills and
//   then s_tready falls until the back end drains.
`include "json_html_safe_escaper_macros.svh"

module json_html_safe_escaper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import jhse_pkg::*;

    cmd_t        f_cmd, q_cmd;
    front_stat_t f_stat;
    queue_stat_t q_stat;
    logic        in_fire;
    logic        pop;
    logic [2:0]  b_idx;

    assign s_tready = !q_stat.full;
    assign in_fire  = s_tvalid && s_tready;

    jhse_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .cmd     (f_cmd),
        .stat    (f_stat)
    );

    jhse_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (f_stat.push),
        .wr_cmd  (f_cmd),
        .pop     (pop),
        .rd_cmd  (q_cmd),
        .stat    (q_stat)
    );

    jhse_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_stat.valid),
        .cmd       (q_cmd),
        .cmd_pop   (pop),
        .idx       (b_idx),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `JHSE_ASSERT_NXT(a_last_clears_hold, in_fire && s_tlast, f_stat.held == HOLD_NONE)
    `JHSE_ASSERT_IMP(a_no_push_when_full, f_stat.push, !q_stat.full)
    `JHSE_ASSERT_IMP(a_idle_back_at_start, !q_stat.valid, b_idx == 3'd0)
    `JHSE_ASSERT_IMP(a_count_in_range, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
endmodule

### test/json_html_safe_escaper_test.sv
// Self-checking testbench for json_html_safe_escaper: drives byte strings with
// bursty valid and stalling ready, predicts the escaped stream, checks each item.
// Depends on jhse_pkg and the json_html_safe_escaper RTL only.
module json_html_safe_escaper_test;
    import jhse_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain_first;
    } text_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } esc_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    text_item_t  pending_text[$];
    esc_item_t   escaped_expect[$];
    hold_state_t held = HOLD_NONE;

    int errors = 0;
    int n_in = 0;
    int n_strings = 0;
    int n_out = 0;
    int n_escapes = 0;
    int burst_left = 8;
    int gap_left = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int rx_mode = 0;
    int rx_cnt = 0;

    json_html_safe_escaper dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // escaped-stream predictor
    function automatic void expect_byte(logic [7:0] b);
        escaped_expect.push_back('{data: b, last: 1'b0});
    endfunction

    function automatic void expect_escape(logic [31:0] hex);
        expect_byte(B_BSL);
        expect_byte(B_U);
        for (int i = 3; i >= 0; i--)
            expect_byte(hex[8*i +: 8]);
        n_escapes++;
    endfunction

    function automatic hold_state_t escape_fresh(logic [7:0] b, logic l);
        if (b == B_AMP)
            expect_escape(HEX_0026);
        else if (b == B_GT)
            expect_escape(HEX_003E);
        else if (b == B_LT)
            expect_escape(HEX_003C);
        else if (b == B_E2 && !l)
            return HOLD_E2;
        else
            expect_byte(b);
        return HOLD_NONE;
    endfunction

    function automatic void predict_escaped(logic [7:0] b, logic l);
        int first;
        first = escaped_expect.size();
        case (held)
            HOLD_E2: begin
                if (b == B_80 && !l) begin
                    held = HOLD_E280;
                    return;
                end
                expect_byte(B_E2);
                held = escape_fresh(b, l);
            end
            HOLD_E280: begin
                if (b == B_A8) begin
                    expect_escape(HEX_2028);
                    held = HOLD_NONE;
                end else if (b == B_A9) begin
                    expect_escape(HEX_2029);
                    held = HOLD_NONE;
                end else begin
                    expect_byte(B_E2);
                    expect_byte(B_80);
                    held = escape_fresh(b, l);
                end
            end
            default: held = escape_fresh(b, l);
        endcase
        if (l && escaped_expect.size() > first)
            escaped_expect[$].last = 1'b1;
    endfunction

    // stimulus
    task automatic add_text(input logic [7:0] b, input logic l, input logic drain = 1'b0);
        pending_text.push_back('{data: b, last: l, drain_first: drain});
    endtask

    task automatic add_random_string(input logic drain);
        logic [7:0] bytes[$];
        int         len;
        logic [7:0] odd_set[4];
        odd_set = '{B_80, B_A8, B_A9, B_E2};
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: bytes.push_back(8'($urandom_range(0, 255)));
                4: begin
                    case ($urandom_range(0, 2))
                        0: bytes.push_back(B_AMP);
                        1: bytes.push_back(B_GT);
                        default: bytes.push_back(B_LT);
                    endcase
                end
                5: begin
                    bytes.push_back(B_E2);
                    bytes.push_back(B_80);
                    bytes.push_back($urandom_range(0, 1) ? B_A9 : B_A8);
                end
                6: begin
                    bytes.push_back(B_E2);
                    bytes.push_back(8'($urandom_range(0, 255)));
                end
                7: begin
                    bytes.push_back(B_E2);
                    bytes.push_back(B_80);
                    bytes.push_back(8'($urandom_range(0, 255)));
                end
                8: begin
                    bytes.push_back(B_E2);
                    bytes.push_back(B_E2);
                    bytes.push_back(B_80);
                end
                default: bytes.push_back(odd_set[$urandom_range(0, 3)]);
            endcase
        end
        foreach (bytes[i])
            add_text(bytes[i], i == bytes.size() - 1, drain && i == 0);
    endtask

    // sender: bursts and gaps, optional drain pause before marked items
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            held = HOLD_NONE;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_escaped(s_tdata, s_tlast);
                n_in++;
                if (s_tlast)
                    n_strings++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_text.size() != 0 &&
                             !(pending_text[0].drain_first && escaped_expect.size() != 0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_text[0].data;
                    s_tlast  <= pending_text[0].last;
                    void'(pending_text.pop_front());
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern switches among four random modes, one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && n_out >= 120) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            rx_cnt++;
            if (rx_cnt % 50 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_cnt % 3 == 0);
            endcase
        end
    end

    // output checker and watchdog
    always @(posedge aclk) begin
        esc_item_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_out++;
                if (escaped_expect.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected item: byte %02h last %0b", m_tdata, m_tlast);
                end else begin
                    want = escaped_expect.pop_front();
                    if (want.data !== m_tdata || want.last !== m_tlast) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch on item %0d: expected byte %02h last %0b, got byte %02h last %0b",
                                     n_out, want.data, want.last, m_tdata, m_tlast);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("json_html_safe_escaper verification failed");
                $finish;
            end
        end
    end

    initial begin
        // escapes, byte extremes
        add_text(8'h00, 1'b0);
        add_text(8'hFF, 1'b0);
        add_text(B_AMP, 1'b0);
        add_text(B_GT, 1'b0);
        add_text(B_LT, 1'b1);
        // line and paragraph separators
        add_text(B_E2, 1'b0);
        add_text(B_80, 1'b0);
        add_text(B_A8, 1'b0);
        add_text(B_E2, 1'b0);
        add_text(B_80, 1'b0);
        add_text(B_A9, 1'b1);
        // held E2 broken by an escaped byte
        add_text(B_E2, 1'b0);
        add_text(B_AMP, 1'b0);
        // held E2 80 broken by an escaped byte: longest expansion
        add_text(B_E2, 1'b0);
        add_text(B_80, 1'b0);
        add_text(B_AMP, 1'b0);
        // new hold after a broken one, then end of string flushes it
        add_text(B_E2, 1'b0);
        add_text(B_E2, 1'b1);
        // held E2 flushed by an 80 that ends the string
        add_text(B_E2, 1'b0);
        add_text(B_80, 1'b1);

        add_random_string(1'b1);
        while (pending_text.size() < 410) begin
            if (pending_text.size() >= 270 && pending_text.size() < 280)
                add_random_string(1'b1);
            else
                add_random_string(1'b0);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_text.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (escaped_expect.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("run covered %0d input items in %0d strings, %0d output items, %0d escapes",
                 n_in, n_strings, n_out, n_escapes);
        $display("with bursty input, receiver stalls, one long hold-off and drain pauses");
        if (errors == 0)
            $display("json_html_safe_escaper verification clean");
        else
            $display("json_html_safe_escaper verification failed");
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/jhse_pkg.sv
design/jhse_front.sv
design/jhse_queue.sv
design/jhse_back.sv
design/json_html_safe_escaper.sv
test/json_html_safe_escaper_test.sv
